@@ sv/aesa_pkg.sv @@
// ----------------------------------------------------------------------------
// aesa_pkg
// shared constants and types for the nearest neighbour search unit
// ----------------------------------------------------------------------------
package aesa_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DIST_WIDTH = 32;
    localparam int CFG_WIDTH  = 7;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_DELIVER = 2'd2;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear;        // start of search
        logic take_dist;    // latch query distance, update best
        logic tbl_wr_a;     // write table at row,col
        logic tbl_wr_b;     // write table at col,row
        logic scan_rd;      // issue table and bound read for scan index
        logic min_rd;       // issue bound read for minimum pass
        logic min_init;
        logic set_pivot;    // take the least point as next pivot
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic found;
    } t_sts;

endpackage

@@ sv/aesa_if.sv @@
// ----------------------------------------------------------------------------
// aesa_in_if / aesa_out_if
// valid ready channels of the search unit
// ----------------------------------------------------------------------------
interface aesa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic [31:0] measured_distance;
    modport source (output valid, opcode, row_index, col_index, measured_distance,
                    input ready);
    modport sink   (input valid, opcode, row_index, col_index, measured_distance,
                    output ready);
endinterface

interface aesa_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [5:0]  pivot_index;
    logic [5:0]  nearest_index;
    logic [31:0] nearest_distance;
    modport source (output valid, result_kind, pivot_index, nearest_index,
                    nearest_distance, input ready);
    modport sink   (input valid, result_kind, pivot_index, nearest_index,
                    nearest_distance, output ready);
endinterface

@@ sv/aesa_ram.sv @@
// ----------------------------------------------------------------------------
// aesa_ram
// simple dual port ram with registered read
// ----------------------------------------------------------------------------
module aesa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/aesa_datapath.sv @@
// ----------------------------------------------------------------------------
// aesa_datapath
// distance table, bound memory, eliminated flags, best and minimum tracking
// ----------------------------------------------------------------------------
module aesa_datapath #(
    parameter int MAX_POINTS = aesa_pkg::MAX_POINTS,
    parameter int DIST_WIDTH = aesa_pkg::DIST_WIDTH,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int TW = 2 * IW
) (
    input  logic                  i_clk,
    input  aesa_pkg::t_cmd        i_cmd,
    input  logic [IW-1:0]         i_row,
    input  logic [IW-1:0]         i_col,
    input  logic [IW-1:0]         i_scan_idx,    // index being read
    input  logic [DIST_WIDTH-1:0] i_dist,
    output aesa_pkg::t_sts        o_sts,
    output logic [IW-1:0]         o_next,
    output logic [IW-1:0]         o_best_index,
    output logic [DIST_WIDTH-1:0] o_best_dist
);
    logic                  tbl_we;
    logic [TW-1:0]         tbl_waddr;
    logic [TW-1:0]         tbl_raddr;
    logic [DIST_WIDTH-1:0] tbl_wdata;
    logic [DIST_WIDTH-1:0] tbl_rdata;
    logic [DIST_WIDTH-1:0] lb_rdata;
    logic [MAX_POINTS-1:0] r_elim;
    logic [DIST_WIDTH-1:0] r_best_dist;
    logic [IW-1:0]         r_best_index;
    logic [IW-1:0]         r_pivot;
    logic [DIST_WIDTH-1:0] r_d;
    logic                  r_found;
    logic [DIST_WIDTH-1:0] r_least;
    logic [IW-1:0]         r_next;
    logic                  r_first;
    logic                  r_upd_v;
    logic [IW-1:0]         r_upd_idx;
    logic                  r_min_v;
    logic [IW-1:0]         r_min_idx;
    logic [DIST_WIDTH-1:0] diff;
    logic [DIST_WIDTH-1:0] lb_cur;
    logic [DIST_WIDTH-1:0] lb_new;

    assign tbl_we    = i_cmd.tbl_wr_a | i_cmd.tbl_wr_b;
    assign tbl_waddr = i_cmd.tbl_wr_b ? {i_col, i_row} : {i_row, i_col};
    assign tbl_wdata = i_cmd.tbl_wr_b ? r_d : i_dist;
    assign tbl_raddr = {r_pivot, i_scan_idx};

    aesa_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_POINTS * MAX_POINTS)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(tbl_wdata),
        .i_raddr(tbl_raddr),
        .o_rdata(tbl_rdata)
    );

    // lower bounds, read in the cycle before the update
    aesa_ram #(.WIDTH(DIST_WIDTH), .DEPTH(MAX_POINTS)) u_lb (
        .i_clk  (i_clk),
        .i_we   (r_upd_v),
        .i_waddr(r_upd_idx),
        .i_wdata(lb_new),
        .i_raddr(i_scan_idx),
        .o_rdata(lb_rdata)
    );

    // first pass after start sees all bounds as zero
    assign diff   = (tbl_rdata >= r_d) ? tbl_rdata - r_d : r_d - tbl_rdata;
    assign lb_cur = r_first ? '0 : lb_rdata;
    assign lb_new = (lb_cur < diff) ? diff : lb_cur;

    always_ff @(posedge i_clk) begin
        r_upd_v   <= i_cmd.scan_rd;
        r_upd_idx <= i_scan_idx;
        r_min_v   <= i_cmd.min_rd;
        r_min_idx <= i_scan_idx;
        if (i_cmd.clear) begin
            r_elim       <= '0;
            r_best_dist  <= '1;
            r_best_index <= '0;
            r_pivot      <= '0;
            r_first      <= 1'b1;
            r_found      <= 1'b0;
            r_next       <= '0;
        end else begin
            if (i_cmd.take_dist || i_cmd.tbl_wr_a) begin
                r_d <= i_dist;
            end
            if (i_cmd.take_dist) begin
                r_elim[r_pivot] <= 1'b1;
                if (i_dist < r_best_dist) begin
                    r_best_dist  <= i_dist;
                    r_best_index <= r_pivot;
                end
            end
            if (r_upd_v) begin
                if (lb_new >= r_best_dist) begin
                    r_elim[r_upd_idx] <= 1'b1;
                end
            end
            if (i_cmd.min_rd) begin
                r_first <= 1'b0;
            end
            if (i_cmd.min_init) begin
                r_found <= 1'b0;
            end else if (r_min_v) begin
                if (!r_elim[r_min_idx] && (!r_found || lb_rdata < r_least)) begin
                    r_found <= 1'b1;
                    r_least <= lb_rdata;
                    r_next  <= r_min_idx;
                end
            end
            if (i_cmd.set_pivot) begin
                r_pivot <= r_next;
            end
        end
    end

    assign o_sts.found  = r_found;
    assign o_next       = r_next;
    assign o_best_index = r_best_index;
    assign o_best_dist  = r_best_dist;
endmodule

@@ sv/aesa_ctrl.sv @@
// ----------------------------------------------------------------------------
// aesa_ctrl
// sequencer for load, start and the per distance passes
// ----------------------------------------------------------------------------
module aesa_ctrl #(
    parameter int MAX_POINTS = aesa_pkg::MAX_POINTS,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_opcode,
    input  logic [5:0]                      i_row_index,
    input  logic [5:0]                      i_col_index,
    input  logic [aesa_pkg::CFG_WIDTH-1:0]  i_points,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic [IW-1:0]                   o_row,
    output logic [IW-1:0]                   o_col,
    output logic [IW-1:0]                   o_scan_idx,
    output aesa_pkg::t_cmd                  o_cmd,
    input  aesa_pkg::t_sts                  i_sts
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOAD_B, S_SCAN, S_MIN, S_DECIDE, S_OUT
    } t_state;

    t_state        r_state;
    logic          r_searching;
    logic [CW-1:0] r_active;
    logic [CW-1:0] r_cnt;
    logic          r_kind;
    logic [IW-1:0] r_row;
    logic [IW-1:0] r_col;
    logic          acc;
    logic          in_range;
    logic [CW-1:0] pts_clip;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;
    assign in_range   = ({1'b0, i_row_index} < 7'(MAX_POINTS))
                     && ({1'b0, i_col_index} < 7'(MAX_POINTS));

    always_comb begin
        if (i_points == '0) begin
            pts_clip = CW'(1);
        end else if (32'(i_points) > MAX_POINTS) begin
            pts_clip = CW'(MAX_POINTS);
        end else begin
            pts_clip = CW'(i_points);
        end
    end

    assign o_row        = r_row;
    assign o_col        = r_col;
    assign o_out_valid  = (r_state == S_OUT);
    assign o_kind       = r_kind;
    assign o_scan_idx   = (r_state == S_IDLE) ? '0 : r_cnt[IW-1:0];

    always_comb begin
        o_cmd           = '0;
        o_cmd.clear     = acc && i_opcode == aesa_pkg::OP_START;
        o_cmd.take_dist = acc && i_opcode == aesa_pkg::OP_DELIVER && r_searching;
        o_cmd.tbl_wr_a  = acc && i_opcode == aesa_pkg::OP_LOAD && !r_searching
                          && in_range;
        o_cmd.tbl_wr_b  = (r_state == S_LOAD_B);
        // last cycle of each pass only completes the pending update
        o_cmd.scan_rd   = (r_state == S_SCAN) && r_cnt < r_active;
        o_cmd.min_init  = o_cmd.take_dist;
        o_cmd.min_rd    = (r_state == S_MIN) && r_cnt < r_active;
        o_cmd.set_pivot = (r_state == S_DECIDE) && i_sts.found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_searching <= 1'b0;
            r_active    <= CW'(1);
            r_cnt       <= '0;
            r_kind      <= aesa_pkg::KIND_REQUEST;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_row <= i_row_index[IW-1:0];
                    r_col <= i_col_index[IW-1:0];
                    r_cnt <= '0;
                    if (o_cmd.clear) begin
                        r_active    <= pts_clip;
                        r_searching <= 1'b1;
                        r_kind      <= aesa_pkg::KIND_REQUEST;
                        r_state     <= S_OUT;
                    end else if (o_cmd.take_dist) begin
                        r_state <= S_SCAN;
                    end else if (o_cmd.tbl_wr_a) begin
                        r_state <= S_LOAD_B;
                    end
                end
                S_LOAD_B: r_state <= S_IDLE;
                S_SCAN: begin
                    if (r_cnt >= r_active) begin
                        r_cnt   <= '0;
                        r_state <= S_MIN;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_MIN: begin
                    if (r_cnt >= r_active) begin
                        r_cnt   <= '0;
                        r_state <= S_DECIDE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DECIDE: begin
                    r_kind <= i_sts.found ? aesa_pkg::KIND_REQUEST : aesa_pkg::KIND_DONE;
                    if (!i_sts.found) begin
                        r_searching <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/aesa_nearest_neighbour_search_unit.sv @@
// ----------------------------------------------------------------------------
// aesa_nearest_neighbour_search_unit
// aesa nearest neighbour search over a loaded table of prototype distances
// ----------------------------------------------------------------------------
// in_ch carries load, start and deliver items; out_ch carries pivot requests
// and the final answer. i_points_wr/i_points_data set the points in use,
// sampled at start; the user must write them only while idle, the block does not enforce it.
// a load makes one ram write per symmetric position (row,col, then col,row).
// a start answers with a request for pivot 0 in the next cycle.
// a deliver runs two passes over the N points in use: one pass updates the
// lower bounds from the pivot row, one ram read per cycle, a second pass
// scans the bounds for the least uneliminated point.
// one item is handled at a time; in_ch is not ready while a result is
// pending, so a stalled receiver holds the unit.
// reset clears the controller and drops any running search; the table is
// not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module aesa_nearest_neighbour_search_unit #(
    parameter int MAX_POINTS = aesa_pkg::MAX_POINTS,
    parameter int DIST_WIDTH = aesa_pkg::DIST_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_points_wr,
    input  logic [aesa_pkg::CFG_WIDTH-1:0] i_points_data,
    aesa_in_if.sink                        in_ch,
    aesa_out_if.source                     out_ch
);
    localparam int IW = $clog2(MAX_POINTS);

    logic [aesa_pkg::CFG_WIDTH-1:0] r_points;
    aesa_pkg::t_cmd        cmd;
    aesa_pkg::t_sts        sts;
    logic [IW-1:0]         row;
    logic [IW-1:0]         col;
    logic [IW-1:0]         scan_idx;
    logic [IW-1:0]         next;
    logic [IW-1:0]         best_index;
    logic [DIST_WIDTH-1:0] best_dist;
    logic                  kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= aesa_pkg::CFG_WIDTH'(1);
        end else if (i_points_wr) begin
            r_points <= i_points_data;
        end
    end

    aesa_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_opcode   (in_ch.opcode),
        .i_row_index(in_ch.row_index),
        .i_col_index(in_ch.col_index),
        .i_points   (r_points),
        .i_out_ready(out_ch.ready),
        .o_out_valid(out_ch.valid),
        .o_kind     (kind),
        .o_row      (row),
        .o_col      (col),
        .o_scan_idx (scan_idx),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    aesa_datapath #(.MAX_POINTS(MAX_POINTS), .DIST_WIDTH(DIST_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_row       (cmd.tbl_wr_a ? in_ch.row_index[IW-1:0] : row),
        .i_col       (cmd.tbl_wr_a ? in_ch.col_index[IW-1:0] : col),
        .i_scan_idx  (scan_idx),
        .i_dist      (in_ch.measured_distance[DIST_WIDTH-1:0]),
        .o_sts       (sts),
        .o_next      (next),
        .o_best_index(best_index),
        .o_best_dist (best_dist)
    );

    assign out_ch.result_kind      = kind;
    assign out_ch.pivot_index      = (kind == aesa_pkg::KIND_REQUEST) ? 6'(next & {IW{sts.found}}) : '0;
    assign out_ch.nearest_index    = (kind == aesa_pkg::KIND_DONE) ? 6'(best_index) : '0;
    assign out_ch.nearest_distance = (kind == aesa_pkg::KIND_DONE) ? 32'(best_dist) : '0;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid)
        else $error("result dropped while stalled");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while result pending");
endmodule

@@ tb/sv/aesa_nearest_neighbour_search_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aesa_nearest_neighbour_search_unit_test
// self-checking test of the aesa nearest neighbour search unit
// ----------------------------------------------------------------------------
// loads distance tables, runs searches with random and well-formed replies,
// predicts every pivot request and answer in the bench and compares each
// transfer on the result channel field by field, under random idling,
// receiver stalls and a long hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module aesa_nearest_neighbour_search_unit_test;

    typedef struct packed {
        logic        kind;
        logic [5:0]  pivot;
        logic [5:0]  nidx;
        logic [31:0] ndist;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic i_points_wr;
    logic [aesa_pkg::CFG_WIDTH-1:0] i_points_data;

    aesa_in_if  in_ch ();
    aesa_out_if out_ch ();

    aesa_nearest_neighbour_search_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_points_wr   (i_points_wr),
        .i_points_data (i_points_data),
        .in_ch         (in_ch.sink),
        .out_ch        (out_ch.source)
    );

    // predictor state
    logic [31:0] dist_tbl [aesa_pkg::MAX_POINTS][aesa_pkg::MAX_POINTS];
    logic [31:0] bound [aesa_pkg::MAX_POINTS];
    bit          gone [aesa_pkg::MAX_POINTS];
    logic [31:0] best_dist;
    logic [5:0]  best_idx;
    logic [5:0]  cur_pivot;
    bit          running;
    int          points_reg;
    int          active_n;

    t_answer answer_queue[$];
    int errors;
    int sent_count;
    int send_idle_pct;
    int recv_stall_pct;
    logic hold_on;

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    function automatic void predict(input logic [1:0] op, input logic [5:0] r,
                                    input logic [5:0] c, input logic [31:0] d);
        t_answer a;
        bit found;
        logic [31:0] least;
        logic [31:0] diff;
        int nxt;
        int n;
        found = 0;
        least = '0;
        nxt = 0;
        if (op == aesa_pkg::OP_LOAD) begin
            if (!running) begin
                dist_tbl[r][c] = d;
                dist_tbl[c][r] = d;
            end
        end else if (op == aesa_pkg::OP_START) begin
            n = points_reg;
            if (n < 1) n = 1;
            if (n > aesa_pkg::MAX_POINTS) n = aesa_pkg::MAX_POINTS;
            active_n = n;
            for (int i = 0; i < aesa_pkg::MAX_POINTS; i++) begin
                bound[i] = '0;
                gone[i] = 0;
            end
            best_dist = '1;
            best_idx = '0;
            cur_pivot = '0;
            running = 1;
            a = '{aesa_pkg::KIND_REQUEST, 6'd0, 6'd0, 32'd0};
            answer_queue = {answer_queue, a};
        end else if (op == aesa_pkg::OP_DELIVER && running) begin
            if (d < best_dist) begin
                best_dist = d;
                best_idx = cur_pivot;
            end
            gone[cur_pivot] = 1;
            for (int i = 0; i < active_n; i++) begin
                diff = (dist_tbl[cur_pivot][i] >= d) ? dist_tbl[cur_pivot][i] - d
                                                     : d - dist_tbl[cur_pivot][i];
                if (bound[i] < diff) bound[i] = diff;
            end
            for (int i = 0; i < active_n; i++) begin
                if (bound[i] >= best_dist) gone[i] = 1;
            end
            for (int i = 0; i < active_n; i++) begin
                if (!gone[i] && (!found || bound[i] < least)) begin
                    found = 1;
                    least = bound[i];
                    nxt = i;
                end
            end
            if (found) begin
                cur_pivot = nxt;
                a = '{aesa_pkg::KIND_REQUEST, 6'(nxt), 6'd0, 32'd0};
            end else begin
                running = 0;
                a = '{aesa_pkg::KIND_DONE, 6'd0, best_idx, best_dist};
            end
            answer_queue = {answer_queue, a};
        end
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [5:0] r,
                             input logic [5:0] c, input logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.row_index <= r;
        in_ch.col_index <= c;
        in_ch.measured_distance <= d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict(op, r, c, d);
        sent_count++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (answer_queue.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2 * aesa_pkg::MAX_POINTS + 10) @(posedge i_clk);
    endtask

    task automatic write_points(input int v);
        in_ch.valid <= 1'b0;
        i_points_wr <= 1'b1;
        i_points_data <= aesa_pkg::CFG_WIDTH'(v);
        @(posedge i_clk);
        i_points_wr <= 1'b0;
        points_reg = v;
    endtask

    task automatic load_table(input int n, input int span);
        for (int i = 0; i < n; i++) begin
            for (int j = i; j < n; j++) begin
                send_item(aesa_pkg::OP_LOAD, 6'(i), 6'(j),
                          (i == j) ? 32'd0 : 32'($urandom_range(span)));
            end
        end
    endtask

    // answer the search with random replies, or replies consistent with a hidden query
    task automatic run_search(input bit noisy, input int n);
        int guard;
        logic [31:0] q;
        int qp;
        qp = $urandom_range(n - 1);
        send_item(aesa_pkg::OP_START, 6'd0, 6'd0, 32'd0);
        guard = 0;
        while (running && guard < 200) begin
            if (noisy) begin
                q = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(4000));
            end else begin
                q = dist_tbl[qp][cur_pivot] + 32'($urandom_range(50));
            end
            send_item(aesa_pkg::OP_DELIVER, 6'd0, 6'd0, q);
            guard++;
        end
    endtask

    task automatic test_directed();
        write_points(0);
        send_item(aesa_pkg::OP_LOAD, 6'd0, 6'd0, 32'hFFFF_FFFF);
        send_item(aesa_pkg::OP_DELIVER, 6'd0, 6'd0, 32'd5);
        send_item(2'd3, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send_item(aesa_pkg::OP_START, 6'd0, 6'd0, 32'd0);
        send_item(aesa_pkg::OP_LOAD, 6'd1, 6'd2, 32'd9);
        send_item(aesa_pkg::OP_DELIVER, 6'd0, 6'd0, 32'hFFFF_FFFF);
        drain();
        write_points(2);
        send_item(aesa_pkg::OP_LOAD, 6'd0, 6'd1, 32'd100);
        send_item(aesa_pkg::OP_LOAD, 6'd1, 6'd1, 32'd0);
        send_item(aesa_pkg::OP_LOAD, 6'd0, 6'd0, 32'd0);
        send_item(aesa_pkg::OP_START, 6'd0, 6'd0, 32'd0);
        send_item(aesa_pkg::OP_START, 6'd0, 6'd0, 32'd0);
        send_item(aesa_pkg::OP_DELIVER, 6'd0, 6'd0, 32'hFFFF_FFFF);
        send_item(aesa_pkg::OP_DELIVER, 6'd0, 6'd0, 32'd0);
        drain();
        // full width search on row 0, every point eliminated by the first reply
        write_points(127);
        for (int j = 0; j < aesa_pkg::MAX_POINTS; j++) begin
            send_item(aesa_pkg::OP_LOAD, 6'd0, 6'(j),
                      (j == 0) ? 32'd0 : 32'(2000 + $urandom_range(5000)));
        end
        send_item(aesa_pkg::OP_START, 6'd0, 6'd0, 32'd0);
        send_item(aesa_pkg::OP_DELIVER, 6'd0, 6'd0, 32'd1000);
        drain();
    endtask

    task automatic test_random(input int items);
        int n;
        int first;
        first = sent_count;
        while (sent_count - first < items) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 16)
                                         : $urandom_range(1, 8);
            write_points(($urandom_range(19) == 0) ? 0 : n);
            if (points_reg == 0) n = 1;
            load_table(n, ($urandom_range(1) != 0) ? 300 : 32'hFFFF_FFFF);
            for (int k = 0; k < 2; k++) begin
                if ($urandom_range(4) == 0) begin
                    send_item(2'($urandom_range(3)), 6'($urandom_range(n - 1)),
                              6'($urandom_range(n - 1)), $urandom);
                end
                run_search($urandom_range(3) == 0, n);
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_points(4);
        load_table(4, 200);
        drain();
        fork
            begin
                hold_on <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join_none
        run_search(1, 4);
        run_search(0, 4);
        drain();
    endtask

    // receiver
    always @(posedge i_clk) begin
        t_answer got;
        t_answer exp_a;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.result_kind, out_ch.pivot_index, out_ch.nearest_index,
                        out_ch.nearest_distance};
                if (answer_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transfer %h", got);
                end else begin
                    exp_a = answer_queue.pop_front();
                    if (got !== exp_a) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch kind %b/%b pivot %0d/%0d idx %0d/%0d dist %h/%h",
                                     exp_a.kind, got.kind, exp_a.pivot, got.pivot,
                                     exp_a.nidx, got.nidx, exp_a.ndist, got.ndist);
                        end
                    end
                end
            end
            if (hold_on) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        errors = 0;
        sent_count = 0;
        hold_on = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        running = 0;
        points_reg = 1;
        active_n = 1;
        best_dist = '1;
        best_idx = '0;
        cur_pivot = '0;
        for (int i = 0; i < aesa_pkg::MAX_POINTS; i++) begin
            bound[i] = '0;
            gone[i] = 0;
            for (int j = 0; j < aesa_pkg::MAX_POINTS; j++) begin
                dist_tbl[i][j] = '0;
            end
        end
        i_rst_n = 1'b0;
        i_points_wr = 1'b0;
        i_points_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = aesa_pkg::OP_LOAD;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.measured_distance = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(100);
        send_idle_pct = 58;
        test_random(100);
        send_idle_pct = 0;
        recv_stall_pct = 58;
        test_random(100);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random(100);
        drain();
        if (errors == 0 && answer_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/aesa_pkg.sv
sv/aesa_if.sv
sv/aesa_ram.sv
sv/aesa_datapath.sv
sv/aesa_ctrl.sv
sv/aesa_nearest_neighbour_search_unit.sv
tb/sv/aesa_nearest_neighbour_search_unit_test.sv
